### hdl/chi_pkg.sv
// ============================================================================
// chi_pkg
// Shared types, widths and constants of the hard-iron compass heading block,
// including the CORDIC arctangent table in degrees with 12 fraction bits.
// ============================================================================
package chi_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int DECL_W     = 9;
    localparam int HEADING_W  = 11;
    localparam int AXES       = 3;
    localparam int ATAN_LEN   = 24;
    localparam int IDX_W      = 5;
    localparam int ATAN_W     = 19;
    localparam int PRESCALE   = 8;
    localparam int VEC_W      = 28;
    localparam int Z_W        = 20;
    localparam int DEG_W      = 23;
    localparam int FRAC_W     = 12;
    localparam int QDEG_SHIFT = 10;

    typedef logic [SAMPLE_W-1:0]         sample_t;
    typedef logic signed [DECL_W-1:0]    decl_t;
    typedef logic [HEADING_W-1:0]        heading_t;
    typedef logic [ATAN_W-1:0]           atan_t;
    typedef logic signed [VEC_W-1:0]     vec_t;
    typedef logic signed [Z_W-1:0]       zacc_t;
    typedef logic signed [DEG_W-1:0]     deg_t;

    localparam sample_t AXIS_RESET = 16'h8000;
    localparam decl_t   DECL_RESET = 9'sd1;

    localparam zacc_t QUARTER_Z      = 20'sd368640;
    localparam deg_t  QUARTER_DEG    = 23'sd368640;
    localparam deg_t  THREE_QTR_DEG  = 23'sd1105920;
    localparam deg_t  FULL_TURN_DEG  = 23'sd1474560;

    function automatic atan_t atan_q12(input logic [IDX_W-1:0] idx);
        atan_t val;
        case (idx)
            5'd0:    val = 19'd184320;
            5'd1:    val = 19'd108810;
            5'd2:    val = 19'd57492;
            5'd3:    val = 19'd29184;
            5'd4:    val = 19'd14649;
            5'd5:    val = 19'd7331;
            5'd6:    val = 19'd3667;
            5'd7:    val = 19'd1833;
            5'd8:    val = 19'd917;
            5'd9:    val = 19'd458;
            5'd10:   val = 19'd229;
            5'd11:   val = 19'd115;
            5'd12:   val = 19'd57;
            5'd13:   val = 19'd29;
            5'd14:   val = 19'd14;
            5'd15:   val = 19'd7;
            5'd16:   val = 19'd4;
            5'd17:   val = 19'd2;
            5'd18:   val = 19'd1;
            default: val = 19'd0;
        endcase
        return val;
    endfunction

endpackage

### hdl/chi_if.sv
// ============================================================================
// chi_if
// Valid/ready channels of the compass block: magnetometer samples in,
// heading and hard-iron centers out.
// ============================================================================
interface chi_sample_if import chi_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t mag_x;
    sample_t mag_y;
    sample_t mag_z;

    modport source (output valid, output mag_x, output mag_y, output mag_z, input ready);
    modport sink   (input valid, input mag_x, input mag_y, input mag_z, output ready);
endinterface

interface chi_result_if import chi_pkg::*; ();
    logic     valid;
    logic     ready;
    heading_t heading_qdeg;
    sample_t  center_x;
    sample_t  center_y;
    sample_t  center_z;

    modport source (output valid, output heading_qdeg, output center_x, output center_y,
                    output center_z, input ready);
    modport sink   (input valid, input heading_qdeg, input center_x, input center_y,
                    input center_z, output ready);
endinterface

### hdl/compass_hard_iron_heading.sv
// ============================================================================
// compass_hard_iron_heading
// Hard-iron calibrated compass heading: running per-axis min/max centers,
// iterative CORDIC arctangent, quadrant placement, declination and wrap.
// ============================================================================
// flow: a taken sample passes through ST_LOAD, ST_PREP, the ST_ITER steps, ST_ANGLE
// and ST_WRAP, where it waits for a free output; no new sample is taken until ST_IDLE,
// since the single CORDIC rotation unit is reused once per step
// a new sample is taken while the previous result still waits at the output
// reset: axis min/max to 0x8000, declination to 1 degree, no result pending
module compass_hard_iron_heading import chi_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  decl_t cfg_wdata,
    chi_sample_if.sink   sample,
    chi_result_if.source result
);

    localparam int NUM_STEPS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(NUM_STEPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PREP,
        ST_ITER,
        ST_ANGLE,
        ST_WRAP
    } state_t;

    state_t           state_reg;
    logic             out_valid_reg;
    decl_t            decl_reg;
    logic [IDX_W-1:0] cnt_reg;
    sample_t          max_reg [AXES];
    sample_t          min_reg [AXES];
    sample_t          max_next [AXES];
    sample_t          min_next [AXES];
    sample_t          center_next [AXES];

    sample_t  samp_reg [AXES];
    sample_t  center_reg [AXES];
    logic     x_lo_reg;
    logic     sub_reg;
    vec_t     vx_reg;
    vec_t     vy_reg;
    zacc_t    z_reg;
    deg_t     deg_reg;
    heading_t heading_reg;
    sample_t  out_cx_reg;
    sample_t  out_cy_reg;
    sample_t  out_cz_reg;

    logic    x_lo;
    logic    y_lo;
    logic    y_hi;
    sample_t dx;
    sample_t dy;
    vec_t    sh_x;
    vec_t    sh_y;
    zacc_t   atan_step;
    vec_t    vx_next;
    vec_t    vy_next;
    zacc_t   z_next;
    atan_t   angle;
    deg_t    angle_ext;
    deg_t    base_deg;
    deg_t    decl_ext;
    deg_t    deg_sum;
    deg_t    deg_wrap;
    logic    out_free;
    logic    in_fire;

    assign sample.ready        = (state_reg == ST_IDLE);
    assign in_fire             = sample.valid && sample.ready;
    assign out_free            = !out_valid_reg || result.ready;
    assign result.valid        = out_valid_reg;
    assign result.heading_qdeg = heading_reg;
    assign result.center_x     = out_cx_reg;
    assign result.center_y     = out_cy_reg;
    assign result.center_z     = out_cz_reg;

    // running extremes and centers
    always_comb
    begin
        for (int k = 0; k < AXES; k++)
        begin
            max_next[k]    = (samp_reg[k] > max_reg[k]) ? samp_reg[k] : max_reg[k];
            min_next[k]    = (samp_reg[k] < min_reg[k]) ? samp_reg[k] : min_reg[k];
            center_next[k] = {1'b0, max_next[k][SAMPLE_W-1:1]}
                           + {1'b0, min_next[k][SAMPLE_W-1:1]};
        end
    end

    // offsets from center and quadrant flags
    always_comb
    begin
        x_lo = samp_reg[0] < center_reg[0];
        y_lo = samp_reg[1] < center_reg[1];
        y_hi = samp_reg[1] > center_reg[1];
        dx   = x_lo ? (center_reg[0] - samp_reg[0]) : (samp_reg[0] - center_reg[0]);
        dy   = y_lo ? (center_reg[1] - samp_reg[1]) : (samp_reg[1] - center_reg[1]);
    end

    // shared cordic vectoring step
    always_comb
    begin
        sh_x      = vx_reg >>> cnt_reg;
        sh_y      = vy_reg >>> cnt_reg;
        atan_step = $signed({1'b0, atan_q12(cnt_reg)});
        vx_next   = vx_reg;
        vy_next   = vy_reg;
        z_next    = z_reg;
        if (vy_reg != '0)
        begin
            if (!vy_reg[VEC_W-1])
            begin
                vx_next = vx_reg + sh_y;
                vy_next = vy_reg - sh_x;
                z_next  = z_reg + atan_step;
            end
            else
            begin
                vx_next = vx_reg - sh_y;
                vy_next = vy_reg + sh_x;
                z_next  = z_reg - atan_step;
            end
        end
    end

    // clamp, quadrant placement, declination and wrap
    always_comb
    begin
        if (z_reg[Z_W-1])
            angle = '0;
        else if (z_reg > QUARTER_Z)
            angle = QUARTER_Z[ATAN_W-1:0];
        else
            angle = z_reg[ATAN_W-1:0];
        angle_ext = $signed({{(DEG_W-ATAN_W){1'b0}}, angle});
        base_deg  = x_lo_reg ? QUARTER_DEG : THREE_QTR_DEG;
        decl_ext  = $signed({{(DEG_W-DECL_W-FRAC_W){decl_reg[DECL_W-1]}}, decl_reg,
                             {FRAC_W{1'b0}}});
        deg_sum   = (sub_reg ? (base_deg - angle_ext) : (base_deg + angle_ext)) + decl_ext;
        if (deg_reg >= FULL_TURN_DEG)
            deg_wrap = deg_reg - FULL_TURN_DEG;
        else if (deg_reg[DEG_W-1])
            deg_wrap = deg_reg + FULL_TURN_DEG;
        else
            deg_wrap = deg_reg;
    end

    // sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            decl_reg      <= DECL_RESET;
            cnt_reg       <= '0;
            for (int k = 0; k < AXES; k++)
            begin
                max_reg[k] <= AXIS_RESET;
                min_reg[k] <= AXIS_RESET;
            end
        end
        else
        begin
            if (cfg_we)
                decl_reg <= cfg_wdata;
            if ((state_reg == ST_WRAP) && out_free)
                out_valid_reg <= 1'b1;
            else if (result.valid && result.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                        state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    for (int k = 0; k < AXES; k++)
                    begin
                        max_reg[k] <= max_next[k];
                        min_reg[k] <= min_next[k];
                    end
                    state_reg <= ST_PREP;
                end
                ST_PREP:
                begin
                    cnt_reg   <= '0;
                    state_reg <= ST_ITER;
                end
                ST_ITER:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP)
                        state_reg <= ST_ANGLE;
                end
                ST_ANGLE:
                begin
                    state_reg <= ST_WRAP;
                end
                ST_WRAP:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    samp_reg[0] <= sample.mag_x;
                    samp_reg[1] <= sample.mag_y;
                    samp_reg[2] <= sample.mag_z;
                end
            end
            ST_LOAD:
            begin
                for (int k = 0; k < AXES; k++)
                    center_reg[k] <= center_next[k];
            end
            ST_PREP:
            begin
                vx_reg   <= $signed({{(VEC_W-SAMPLE_W-PRESCALE){1'b0}}, dx, {PRESCALE{1'b0}}});
                vy_reg   <= $signed({{(VEC_W-SAMPLE_W-PRESCALE){1'b0}}, dy, {PRESCALE{1'b0}}});
                z_reg    <= '0;
                x_lo_reg <= x_lo;
                sub_reg  <= x_lo ? y_hi : y_lo;
            end
            ST_ITER:
            begin
                vx_reg <= vx_next;
                vy_reg <= vy_next;
                z_reg  <= z_next;
            end
            ST_ANGLE:
            begin
                deg_reg <= deg_sum;
            end
            ST_WRAP:
            begin
                if (out_free)
                begin
                    heading_reg <= deg_wrap[HEADING_W+QDEG_SHIFT-1:QDEG_SHIFT];
                    out_cx_reg  <= center_reg[0];
                    out_cy_reg  <= center_reg[1];
                    out_cz_reg  <= center_reg[2];
                end
            end
            default:
            begin
                deg_reg <= deg_reg;
            end
        endcase
    end

endmodule

### bench/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the hard-iron compass heading block. A predictor
// tracks the per-axis extremes and works out each heading and center set as
// samples are taken. Samples start near the reset center and spread wider
// phase by phase, under several declination settings. The sender idles in
// bursts and the receiver stalls. Field extremes and full-range samples
// close the run.
// ============================================================================
module tb;
    import chi_pkg::*;

    localparam int STEPS        = 16;
    localparam int DRAIN_CYCLES = STEPS + 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_SHOWN    = 10;

    typedef struct packed {
        heading_t heading_qdeg;
        sample_t  center_x;
        sample_t  center_y;
        sample_t  center_z;
    } heading_result_t;

    typedef enum int {RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_BURSTY} rx_mode_t;

    logic  clk;
    logic  rst_n;
    logic  cfg_we;
    decl_t cfg_wdata;

    chi_sample_if smp ();
    chi_result_if res ();

    compass_hard_iron_heading #(.CORDIC_STEPS(STEPS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .sample    (smp),
        .result    (res)
    );

    sample_t         trk_max [3];
    sample_t         trk_min [3];
    decl_t           decl_setting;
    heading_result_t expected_headings [$];
    longint          atan_tab [24] = '{184320, 108810, 57492, 29184, 14649, 7331, 3667,
                                       1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1,
                                       0, 0, 0, 0, 0};

    int mismatch_count;
    int samples_sent;
    int results_checked;
    int decl_writes;
    int burst_left;
    bit hold_request;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic sample_t axis_center(input int k);
        return (trk_max[k] >> 1) + (trk_min[k] >> 1);
    endfunction

    function automatic longint cordic_angle(input longint ox, input longint oy);
        longint vx;
        longint vy;
        longint nx;
        longint ang;
        vx  = ox <<< 8;
        vy  = oy <<< 8;
        ang = 0;
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            if (vy == 0)
                break;
            if (vy > 0)
            begin
                nx  = vx + (vy >>> i);
                vy  = vy - (vx >>> i);
                ang = ang + atan_tab[i];
            end
            else
            begin
                nx  = vx - (vy >>> i);
                vy  = vy + (vx >>> i);
                ang = ang - atan_tab[i];
            end
            vx = nx;
        end
        if (ang < 0)
            ang = 0;
        if (ang > 368640)
            ang = 368640;
        return ang;
    endfunction

    function automatic heading_result_t predict_heading(input sample_t sx, input sample_t sy,
                                                        input sample_t sz);
        heading_result_t r;
        sample_t         s [3];
        sample_t         c [3];
        longint          dx;
        longint          dy;
        longint          a;
        longint          deg;
        s[0] = sx;
        s[1] = sy;
        s[2] = sz;
        for (int k = 0; k < 3; k++)
        begin
            if (s[k] > trk_max[k])
                trk_max[k] = s[k];
            if (s[k] < trk_min[k])
                trk_min[k] = s[k];
            c[k] = axis_center(k);
        end
        dx = (s[0] < c[0]) ? longint'(c[0] - s[0]) : longint'(s[0] - c[0]);
        dy = (s[1] < c[1]) ? longint'(c[1] - s[1]) : longint'(s[1] - c[1]);
        a  = cordic_angle(dx, dy);
        if (s[0] < c[0])
            deg = (s[1] > c[1]) ? 368640 - a : 368640 + a;
        else
            deg = (s[1] < c[1]) ? 1105920 - a : 1105920 + a;
        deg = deg + longint'(decl_setting) * 4096;
        while (deg >= 1474560)
            deg = deg - 1474560;
        while (deg < 0)
            deg = deg + 1474560;
        r.heading_qdeg = heading_t'(deg >>> 10);
        r.center_x     = c[0];
        r.center_y     = c[1];
        r.center_z     = c[2];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= MAX_SHOWN)
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
    endtask

    always @(posedge clk)
    begin : check_results
        heading_result_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_headings.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("%0t: result transaction with nothing expected, heading %0d",
                             $realtime, res.heading_qdeg);
            end
            else
            begin
                want = expected_headings.pop_front();
                results_checked++;
                if (res.heading_qdeg !== want.heading_qdeg)
                    report_mismatch("heading_qdeg", want.heading_qdeg, res.heading_qdeg);
                if (res.center_x !== want.center_x)
                    report_mismatch("center_x", want.center_x, res.center_x);
                if (res.center_y !== want.center_y)
                    report_mismatch("center_y", want.center_y, res.center_y);
                if (res.center_z !== want.center_z)
                    report_mismatch("center_z", want.center_z, res.center_z);
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver stall pattern and long hold-off
    // ------------------------------------------------------------------
    initial
    begin : receiver
        rx_mode_t mode;
        int       mode_left;
        res.ready <= 1'b0;
        mode      = RX_STEADY;
        mode_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                res.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (mode_left == 0)
            begin
                mode      = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (mode)
                RX_STEADY: res.ready <= 1'b1;
                RX_MOSTLY: res.ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: res.ready <= ($urandom_range(0, 3) == 0);
                default:   res.ready <= ((mode_left % 24) < 6);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sample sender and configuration
    // ------------------------------------------------------------------
    task automatic send_sample(input sample_t sx, input sample_t sy, input sample_t sz);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 45);
            if (gap > 0)
            begin
                smp.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        smp.valid <= 1'b1;
        smp.mag_x <= sx;
        smp.mag_y <= sy;
        smp.mag_z <= sz;
        do
            @(posedge clk);
        while (!smp.ready);
        expected_headings.push_back(predict_heading(sx, sy, sz));
        samples_sent++;
    endtask

    task automatic stop_sending();
        smp.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
    endtask

    task automatic wait_for_drain();
        stop_sending();
        while (expected_headings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_declination(input decl_t value);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        decl_setting = value;
        decl_writes++;
    endtask

    // near the reset center with a span of 2**k, sometimes exactly on the tracked axis center
    function automatic sample_t spread_value(input int k, input int axis);
        int span;
        if ($urandom_range(0, 7) == 0)
            return axis_center(axis);
        span = 1 << k;
        return sample_t'(32768 + int'($urandom_range(0, 2 * span - 1)) - span);
    endfunction

    task automatic send_spread(input int k);
        send_sample(spread_value(k, 0), spread_value(k, 1), spread_value(k, 2));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_zero_vector();
        send_sample(AXIS_RESET, AXIS_RESET, AXIS_RESET);
        send_sample(AXIS_RESET, AXIS_RESET, AXIS_RESET);
        stop_sending();
    endtask

    task automatic test_quadrants();
        send_sample(16'h7F00, 16'h8100, 16'h8000);
        send_sample(16'h7F00, 16'h7F00, 16'h8001);
        send_sample(16'h8100, 16'h7F00, 16'h7FFF);
        send_sample(16'h8100, 16'h8100, 16'h8000);
        send_sample(axis_center(0), 16'h80C0, 16'h8000);
        send_sample(axis_center(0), 16'h7F40, 16'h8000);
        send_sample(16'h7F40, axis_center(1), 16'h8000);
        send_sample(16'h80C0, axis_center(1), 16'h8000);
        stop_sending();
    endtask

    task automatic test_declination_extremes();
        decl_t settings [5] = '{9'sd0, 9'sd180, -9'sd180, 9'sd255, -9'sd256};
        foreach (settings[i])
        begin
            write_declination(settings[i]);
            send_spread(8);
            send_spread(8);
        end
        stop_sending();
    endtask

    task automatic test_growing_spread();
        decl_t value;
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0:       value = decl_t'($urandom_range(0, 511));
                1:       value = 9'sd1;
                2:       value = ($urandom_range(0, 1) != 0) ? 9'sd255 : -9'sd256;
                default: value = -9'sd90;
            endcase
            write_declination(value);
            for (int n = 0; n < 45; n++)
                send_spread(9 + (phase * 6) / 7 + $urandom_range(0, 1));
        end
        stop_sending();
    endtask

    task automatic test_receiver_hold();
        wait_for_drain();
        hold_request = 1'b1;
        burst_left   = 40;
        for (int n = 0; n < 20; n++)
            send_spread(15);
        wait_for_drain();
    endtask

    task automatic test_field_extremes();
        write_declination(DECL_RESET);
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'h0000, 16'hFFFF, 16'h0000);
        send_sample(16'hFFFF, 16'h0000, 16'hFFFF);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        stop_sending();
    endtask

    task automatic test_full_range();
        write_declination(decl_t'($urandom_range(0, 511)));
        for (int n = 0; n < 60; n++)
            send_sample(sample_t'($urandom_range(0, 65535)), sample_t'($urandom_range(0, 65535)),
                        sample_t'($urandom_range(0, 65535)));
        stop_sending();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        smp.valid <= 1'b0;
        smp.mag_x <= '0;
        smp.mag_y <= '0;
        smp.mag_z <= '0;
        for (int k = 0; k < 3; k++)
        begin
            trk_max[k] = AXIS_RESET;
            trk_min[k] = AXIS_RESET;
        end
        decl_setting    = DECL_RESET;
        mismatch_count  = 0;
        samples_sent    = 0;
        results_checked = 0;
        decl_writes     = 0;
        burst_left      = 0;
        hold_request    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_vector();
        test_quadrants();
        test_declination_extremes();
        test_growing_spread();
        test_receiver_hold();
        test_field_extremes();
        test_full_range();

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d samples sent, %0d results checked, %0d declination writes",
                 samples_sent, results_checked, decl_writes);
        $display("covered zero vectors, all quadrants, widening spreads, hold-off, extremes");
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
